[design/unrs_pkg.sv]
// Shared widths, defaults and codes for the undo number reservation set.
package unrs_pkg;

  localparam int unsigned SLOTS_DEF = 32;
  localparam int unsigned UNDO_W    = 64;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned STATUS_W  = 2;

  localparam logic [REQ_W-1:0] REQ_RESERVE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUP     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd3;

  localparam logic [UNDO_W-1:0] LIMIT_STEP = 64'd1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

endpackage

[design/undo_number_reservation_set_unit.sv]
// Top level of the undo number reservation set: scan sequencer, valid bits and count.
// A result strobes on done_o after the scan has checked every slot and the finishing state has passed.
// The block takes no new item while busy: the scan holds the single read port of the slot
// memory and walks it one slot per cycle.
// Reset clears the valid bits and the slot count at once; slot values are not cleared.
// Results cannot be stalled: done_o marks each result for exactly one cycle.
module undo_number_reservation_set_unit
  import unrs_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [UNDO_W-1:0]   undo_no_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [UNDO_W-1:0]   trunc_limit_o,
  output logic [COUNT_W-1:0]  used_count_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // Control state.
  state_e            state_q, state_d;
  logic [SLOTS-1:0]  valid_q;
  logic [CNT_W-1:0]  used_q;
  logic              done_q;

  // Scan pipeline: the read address goes out in the cycle before its data is checked.
  logic [IDX_W-1:0]  issue_idx_q;
  logic              proc_vld_q;
  logic [IDX_W-1:0]  proc_idx_q;

  // The item under work.
  logic [REQ_W-1:0]  req_q;
  logic [UNDO_W-1:0] num_q;

  // Scan results gathered slot by slot.
  logic              match_q, free_q, any_q;
  logic [IDX_W-1:0]  match_idx_q, free_idx_q;
  logic [UNDO_W-1:0] max_q;

  // Result registers.
  logic [STATUS_W-1:0] status_q, status_d;
  logic [UNDO_W-1:0]   limit_q, limit_d;

  logic              accept;
  logic              ram_re, ram_we;
  logic [UNDO_W-1:0] ram_rdata;
  logic              slot_vld, slot_eq;
  logic              do_reserve, do_release;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  unrs_ram #(
    .WIDTH (UNDO_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx_q),
    .wdata_i (num_q),
    .re_i    (ram_re),
    .raddr_i (issue_idx_q),
    .rdata_o (ram_rdata)
  );

  assign ram_re   = (state_q == ST_SCAN);
  assign slot_vld = valid_q[proc_idx_q];
  assign slot_eq  = (ram_rdata == num_q);

  // In the finishing cycle the gathered scan results decide the outcome. The memory
  // is not read then, so the write needs no forwarding.
  assign do_reserve = (state_q == ST_FIN) && (req_q == REQ_RESERVE) && !match_q && free_q;
  assign do_release = (state_q == ST_FIN) && (req_q == REQ_RELEASE) && match_q;
  assign ram_we     = do_reserve;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Once the last address is issued, wait for its data to be checked.
        if (proc_vld_q && proc_idx_q == LAST_IDX) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Status and truncation limit for the item being finished.
  always_comb begin
    status_d = STATUS_OK;
    limit_d  = '0;
    case (req_q)
      REQ_RESERVE: begin
        if (match_q) begin
          status_d = STATUS_DUP;
        end else if (!free_q) begin
          status_d = STATUS_FULL;
        end
      end
      REQ_RELEASE: begin
        if (!match_q) begin
          status_d = STATUS_MISSING;
        end
      end
      REQ_QUERY: begin
        if (any_q && max_q >= num_q) begin
          // The incremented limit saturates at all ones.
          limit_d = (&max_q) ? max_q : max_q + LIMIT_STEP;
        end else begin
          limit_d = num_q;
        end
      end
      default: begin
        status_d = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      used_q      <= '0;
      done_q      <= 1'b0;
      issue_idx_q <= '0;
      proc_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_FIN);

      if (accept) begin
        issue_idx_q <= '0;
      end else if (ram_re && issue_idx_q != LAST_IDX) begin
        issue_idx_q <= issue_idx_q + IDX_W'(1);
      end

      // The last address is read again but checked only once; after that the scan only drains.
      proc_vld_q <= ram_re && !(proc_vld_q && proc_idx_q == LAST_IDX);

      if (do_reserve) begin
        valid_q[free_idx_q] <= 1'b1;
        used_q              <= used_q + CNT_W'(1);
      end else if (do_release) begin
        valid_q[match_idx_q] <= 1'b0;
        if (used_q != '0) begin
          used_q <= used_q - CNT_W'(1);
        end
      end
    end
  end

  // Payload and scan accumulators carry no reset.
  always_ff @(posedge clk_i) begin
    proc_idx_q <= issue_idx_q;
    if (accept) begin
      req_q   <= req_type_i;
      num_q   <= undo_no_i;
      match_q <= 1'b0;
      free_q  <= 1'b0;
      any_q   <= 1'b0;
      max_q   <= '0;
    end else if (proc_vld_q) begin
      if (slot_vld) begin
        any_q <= 1'b1;
        if (!any_q || ram_rdata > max_q) begin
          max_q <= ram_rdata;
        end
        if (slot_eq && !match_q) begin
          match_q     <= 1'b1;
          match_idx_q <= proc_idx_q;
        end
      end else if (!free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= proc_idx_q;
      end
    end
    if (state_q == ST_FIN) begin
      status_q <= status_d;
      limit_q  <= limit_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign trunc_limit_o = limit_q;
  assign used_count_o  = COUNT_W'(used_q);

  // The slot count always agrees with the valid bits.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q == CNT_W'($countones(valid_q)))
    else $error("slot count disagrees with valid bits");

  // A result strobe follows only the finishing cycle.
  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_FIN))
    else $error("result strobe without a finished item");

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("block not busy after accepting an item");

  // The memory is never written while the scan reads it.
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("slot memory written during a scan");

endmodule

[design/unrs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module unrs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
